@@ rtl/core/median_filter_3x3_defines.svh @@
// Assertion macros shared by the median filter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define MF3_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define MF3_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mf3_pkg.sv @@
// Shared types, constants and compare helpers for the 3x3 median filter.
// Used by every module of the block; depends on nothing else.
package mf3_pkg;

    localparam int PIX_W         = 8;
    localparam int FW_W          = 11;
    localparam int FH_W          = 13;
    localparam int ROW_W         = 13;   // holds up to MAX_HEIGHT + 1
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 13;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix [2:0] t_col;       // [0] top row .. [2] bottom row

    typedef struct packed {
        logic mode;
        t_pix red_value;
    } t_in_beat;

    typedef struct packed {
        t_pix median_value;
        logic frame_last;
    } t_out_beat;

    // Per-item control decided at the counters, carried to the window stage
    typedef struct packed {
        logic wr;         // item updates line stores and window
        logic col_first;  // column zero: start of a new row
        logic row_ge1;    // row above exists
        logic row_ge2;    // two rows above exist
        logic row_in;     // current row lies inside the frame
        logic emit;       // item produces a result
        logic last;       // result is the frame's final one
        logic clr;        // window returns to zero after this item
    } t_op;

    // Three-input compare-exchange sort, ascending
    function automatic t_col sort3(input t_col v);
        t_pix a;
        t_pix b;
        t_pix c;
        t_pix t;
        t_col s;
        a = v[0];
        b = v[1];
        c = v[2];
        if (a > b) begin
            t = a; a = b; b = t;
        end
        if (b > c) begin
            t = b; b = c; c = t;
        end
        if (a > b) begin
            t = a; a = b; b = t;
        end
        s[0] = a;
        s[1] = b;
        s[2] = c;
        return s;
    endfunction

endpackage

@@ rtl/core/mf3_line_buf.sv @@
// Line stores for the two previous rows, one read and one write per cycle.
// Depends on mf3_pkg and the assertion macros header.
`include "median_filter_3x3_defines.svh"

module mf3_line_buf #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [COL_W-1:0]      i_rd_addr,
    input  logic                  i_we,
    input  logic [COL_W-1:0]      i_wr_addr,
    input  mf3_pkg::t_pix         i_wr_p,
    input  mf3_pkg::t_pix         i_wr_pp,
    output mf3_pkg::t_pix         o_q_p,
    output mf3_pkg::t_pix         o_q_pp
);
    mf3_pkg::t_pix r_mem_p  [MAX_WIDTH];
    mf3_pkg::t_pix r_mem_pp [MAX_WIDTH];
    mf3_pkg::t_pix r_q_p;
    mf3_pkg::t_pix r_q_pp;
    mf3_pkg::t_pix r_fwd_p;
    mf3_pkg::t_pix r_fwd_pp;
    logic          r_fwd;

    // Memories: synchronous write, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_p[i_wr_addr]  <= i_wr_p;
            r_mem_pp[i_wr_addr] <= i_wr_pp;
        end
        if (i_rd_en) begin
            r_q_p  <= r_mem_p[i_rd_addr];
            r_q_pp <= r_mem_pp[i_rd_addr];
        end
    end

    // Read hitting the entry written in the same cycle takes the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_we && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_p  <= i_wr_p;
            r_fwd_pp <= i_wr_pp;
        end
    end

    assign o_q_p  = r_fwd ? r_fwd_p  : r_q_p;
    assign o_q_pp = r_fwd ? r_fwd_pp : r_q_pp;

    `MF3_ASSERT_NXT(a_rd_during_wr, i_clk, i_rst_n, i_rd_en && i_we && (i_wr_addr == i_rd_addr), (o_q_p == $past(i_wr_p)) && (o_q_pp == $past(i_wr_pp)), "line store read missed same-cycle write")

endmodule

@@ rtl/core/mf3_ctrl.sv @@
// Configuration registers and raster counters; decides what each beat does.
// Depends on mf3_pkg and the assertion macros header.
`include "median_filter_3x3_defines.svh"

module mf3_ctrl #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_fire,
    input  logic                            i_mode,
    output mf3_pkg::t_op                    o_op,
    output logic                            o_op_vld,
    output logic [COL_W-1:0]                o_addr
);
    localparam int ROW_W = mf3_pkg::ROW_W;
    localparam int FW_W  = mf3_pkg::FW_W;
    localparam int FH_W  = mf3_pkg::FH_W;

    localparam logic [COL_W:0]   W_ONE   = (COL_W+1)'(1);
    localparam logic [COL_W:0]   W_MAX   = (COL_W+1)'(MAX_WIDTH);
    localparam logic [FH_W-1:0]  H_ONE   = FH_W'(1);
    localparam logic [FH_W-1:0]  H_MAX   = FH_W'(mf3_pkg::MAX_HEIGHT);
    localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'(mf3_pkg::MAX_HEIGHT + 1);

    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [COL_W:0]   w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [ROW_W-1:0] h_plus1;
    logic [COL_W:0]   col_inc;
    logic             wrap;
    logic             over;
    mf3_pkg::t_op     op;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= mf3_pkg::FW_RESET;
            r_fh <= mf3_pkg::FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mf3_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg_wdata[FW_W-1:0];
                mf3_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp frame size to the supported range
    always_comb begin
        if (r_fw == '0) begin
            w_eff = W_ONE;
        end else if (32'(r_fw) > 32'(MAX_WIDTH)) begin
            w_eff = W_MAX;
        end else begin
            w_eff = (COL_W+1)'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = H_ONE;
        end else if (r_fh > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = r_fh;
        end
    end

    assign h_plus1 = ROW_W'(h_eff) + ROW_ONE;
    assign col_inc = {1'b0, r_col} + W_ONE;
    assign wrap    = col_inc >= w_eff;
    assign over    = r_row > h_plus1;

    // Beat decode
    always_comb begin
        op.wr        = !over;
        op.col_first = (r_col == '0);
        op.row_ge1   = (r_row != '0);
        op.row_ge2   = |r_row[ROW_W-1:1];
        op.row_in    = r_row < ROW_W'(h_eff);
        op.emit      = !over && (op.col_first ? op.row_ge2 : op.row_ge1);
        op.last      = !over && (r_row == h_plus1);
        op.clr       = over || op.last;
    end

    // Flush beats inside the frame are dropped without effect
    assign o_op_vld = over || !(i_mode && op.row_in);
    assign o_op     = op;
    assign o_addr   = r_col;

    // Raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_fire && o_op_vld) begin
            if (op.clr) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap) begin
                r_col <= '0;
                r_row <= r_row + ROW_ONE;
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

    `MF3_ASSERT_IMP(a_row_bound, i_clk, i_rst_n, 1'b1, r_row <= ROW_LIM, "row counter beyond frame end")

endmodule

@@ rtl/core/mf3_median.sv @@
// Three-stage median-of-nine network: column sort, row extremes, final median.
// Depends on mf3_pkg.
module mf3_median (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  mf3_pkg::t_col  i_col_l,
    input  mf3_pkg::t_col  i_col_m,
    input  mf3_pkg::t_col  i_col_r,
    input  logic           i_last,
    output logic           o_vld,
    output mf3_pkg::t_pix  o_med,
    output logic           o_last
);
    mf3_pkg::t_col r_raw [3];
    mf3_pkg::t_col r_srt [3];
    mf3_pkg::t_pix r_lo;
    mf3_pkg::t_pix r_mi;
    mf3_pkg::t_pix r_hi;
    logic          r_l1, r_l2, r_l3;
    logic          r_v1, r_v2, r_v3;

    mf3_pkg::t_col s_lo;
    mf3_pkg::t_col s_mi;
    mf3_pkg::t_col s_hi;
    mf3_pkg::t_col s_out;

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Max of minima, median of middles, min of maxima
    always_comb begin
        s_lo = mf3_pkg::sort3({r_srt[2][0], r_srt[1][0], r_srt[0][0]});
        s_mi = mf3_pkg::sort3({r_srt[2][1], r_srt[1][1], r_srt[0][1]});
        s_hi = mf3_pkg::sort3({r_srt[2][2], r_srt[1][2], r_srt[0][2]});
        s_out = mf3_pkg::sort3({r_hi, r_mi, r_lo});
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_raw[0] <= i_col_l;
            r_raw[1] <= i_col_m;
            r_raw[2] <= i_col_r;
            r_l1     <= i_last;
            for (int k = 0; k < 3; k++) begin
                r_srt[k] <= mf3_pkg::sort3(r_raw[k]);
            end
            r_l2 <= r_l1;
            r_lo <= s_lo[2];
            r_mi <= s_mi[1];
            r_hi <= s_hi[0];
            r_l3 <= r_l2;
        end
    end

    assign o_vld  = r_v3;
    assign o_med  = s_out[1];
    assign o_last = r_l3;

endmodule

@@ rtl/core/median_filter_3x3.sv @@
// 3x3 median filter for one 8-bit channel. Streams one pixel per clock in raster
// order while the input is not stalled; each beat is read from and written back to
// two line memories (one read and one write port each), so the rate is one beat per
// cycle and the result is registered at the output. Results trail the input by one
// row plus one pixel, so after a frame's last pixel the source sends frame_width + 1
// flush beats; frame_last marks the final result. Out-of-frame neighbors count as
// zero. Input stall rises only while a result sits in the output register unread.
// Depends on mf3_pkg, mf3_ctrl, mf3_line_buf, mf3_median and the macros header.
`include "median_filter_3x3_defines.svh"

module median_filter_3x3 #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mf3_pkg::t_in_beat               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mf3_pkg::t_out_beat              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    localparam int COL_W = $clog2(MAX_WIDTH);

    logic               advance;
    logic               in_fire;
    mf3_pkg::t_op       op;
    logic               op_vld;
    logic [COL_W-1:0]   addr;

    logic               r_s1_vld;
    mf3_pkg::t_op       r_s1_op;
    logic [COL_W-1:0]   r_s1_addr;
    mf3_pkg::t_pix      r_s1_pix;
    logic               s1_fire;

    mf3_pkg::t_pix      q_p;
    mf3_pkg::t_pix      q_pp;
    mf3_pkg::t_col      col;
    mf3_pkg::t_col      col_r;
    mf3_pkg::t_col      r_win_a;
    mf3_pkg::t_col      r_win_b;

    logic               med_vld;
    mf3_pkg::t_pix      med;
    logic               med_last;

    logic               r_out_vld;
    mf3_pkg::t_out_beat r_out_data;

    // Whole pipeline moves unless a result is held at the output
    assign advance    = !(r_out_vld && i_out_stall);
    assign o_in_stall = !advance;
    assign in_fire    = i_in_valid && advance;

    mf3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (in_fire),
        .i_mode      (i_in_data.mode),
        .o_op        (op),
        .o_op_vld    (op_vld),
        .o_addr      (addr)
    );

    // Window stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (advance) begin
            r_s1_vld <= in_fire && op_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op   <= op;
            r_s1_addr <= addr;
            r_s1_pix  <= i_in_data.red_value;
        end
    end

    assign s1_fire = r_s1_vld && advance;

    mf3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire && op_vld && op.wr),
        .i_rd_addr (addr),
        .i_we      (s1_fire && r_s1_op.wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_p    (col[2]),
        .i_wr_pp   (col[1]),
        .o_q_p     (q_p),
        .o_q_pp    (q_pp)
    );

    // New column, rows outside the frame gated to zero
    always_comb begin
        col[0] = r_s1_op.row_ge2 ? q_pp : '0;
        col[1] = r_s1_op.row_ge1 ? q_p  : '0;
        col[2] = r_s1_op.row_in  ? r_s1_pix : '0;
        col_r  = r_s1_op.col_first ? '0 : col;
    end

    // Window keeps the two most recent columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_a <= '0;
            r_win_b <= '0;
        end else if (s1_fire) begin
            if (r_s1_op.clr) begin
                r_win_a <= '0;
                r_win_b <= '0;
            end else if (r_s1_op.col_first) begin
                r_win_a <= '0;
                r_win_b <= col;
            end else begin
                r_win_a <= r_win_b;
                r_win_b <= col;
            end
        end
    end

    mf3_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (advance),
        .i_vld   (s1_fire && r_s1_op.emit),
        .i_col_l (r_win_a),
        .i_col_m (r_win_b),
        .i_col_r (col_r),
        .i_last  (r_s1_op.last),
        .o_vld   (med_vld),
        .o_med   (med),
        .o_last  (med_last)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= med_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && med_vld) begin
            r_out_data.median_value <= med;
            r_out_data.frame_last   <= med_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    `MF3_ASSERT_NXT(a_win_clear, i_clk, i_rst_n, s1_fire && r_s1_op.clr, (r_win_a == '0) && (r_win_b == '0), "window not cleared at frame restart")

endmodule

@@ bench/mf3_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the 3x3 median filter: mirrors frame counters, line stores
// and the window on every accepted beat, then compares each result beat in order.
// Depends on mf3_pkg only.
module mf3_checker #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  mf3_pkg::t_in_beat               i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  mf3_pkg::t_out_beat              i_out_data,
    input  logic                            i_cfg_we,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                              o_pending,
    output int                              o_errors
);

    // Mirrored configuration and frame state
    logic [mf3_pkg::FW_W-1:0]  width_reg;
    logic [mf3_pkg::FH_W-1:0]  height_reg;
    mf3_pkg::t_pix             line_above [MAX_WIDTH];
    mf3_pkg::t_pix             line_two_above [MAX_WIDTH];
    logic [2:0][2:0][7:0]      window;     // [column left..right][row top..bottom]
    int unsigned               col_pos;
    logic [mf3_pkg::ROW_W-1:0] row_pos;

    mf3_pkg::t_out_beat        medians_due [$];
    mf3_pkg::t_out_beat        due;
    int                        mismatches = 0;

    // Median of nine: order the five smallest, take the fifth
    function automatic mf3_pkg::t_pix median_of_nine(input logic [8:0][7:0] taps);
        mf3_pkg::t_pix v [9];
        mf3_pkg::t_pix t;
        for (int i = 0; i < 9; i++) v[i] = taps[i];
        for (int i = 0; i < 5; i++) begin
            for (int j = i + 1; j < 9; j++) begin
                if (v[j] < v[i]) begin
                    t = v[i];
                    v[i] = v[j];
                    v[j] = t;
                end
            end
        end
        return v[4];
    endfunction

    task automatic restart_frame();
        window  = '0;
        col_pos = 0;
        row_pos = '0;
    endtask

    // Advance the mirrored filter by one beat; queue the result it causes, if any
    task automatic predict_median(input mf3_pkg::t_in_beat beat);
        int unsigned          w;
        int unsigned          h;
        int unsigned          r;
        int unsigned          c;
        logic [2:0][7:0]      fresh;   // incoming column, [0] top .. [2] bottom
        logic                 emit;
        logic                 last;
        mf3_pkg::t_out_beat   res;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 :
            (height_reg > mf3_pkg::MAX_HEIGHT) ? mf3_pkg::MAX_HEIGHT : height_reg;
        r = row_pos;
        c = col_pos;
        // row counter past the frame: start over silently
        if (r > h + 1) begin
            restart_frame();
            return;
        end
        // flush while pixels are still due: no effect
        if (beat.mode && r < h) return;

        fresh[0] = (r >= 2 && c < MAX_WIDTH) ? line_two_above[c] : '0;
        fresh[1] = (r >= 1 && c < MAX_WIDTH) ? line_above[c] : '0;
        fresh[2] = (r < h) ? beat.red_value : '0;
        if (c < MAX_WIDTH) begin
            line_two_above[c] = fresh[1];
            line_above[c]     = fresh[2];
        end

        emit = 1'b0;
        res  = '0;
        if (c == 0) begin
            // closes the previous row: its right neighbor is padding
            if (r >= 2) begin
                res.median_value = median_of_nine({24'd0, window[2], window[1]});
                emit = 1'b1;
            end
            window = {fresh, 48'd0};
        end else begin
            window = {fresh, window[2], window[1]};
            if (r >= 1) begin
                res.median_value = median_of_nine(window);
                emit = 1'b1;
            end
        end

        last = (r == h + 1);
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        if (last) restart_frame();

        if (emit) begin
            res.frame_last = last;
            medians_due.push_back(res);
        end
    endtask

    // Watch the ports: configuration writes, result beats, input beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = mf3_pkg::FW_RESET;
            height_reg = mf3_pkg::FH_RESET;
            restart_frame();
            medians_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mf3_pkg::CFG_FRAME_WIDTH)
                    width_reg = i_cfg_wdata[mf3_pkg::FW_W-1:0];
                else if (i_cfg_index == mf3_pkg::CFG_FRAME_HEIGHT)
                    height_reg = i_cfg_wdata[mf3_pkg::FH_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (medians_due.size() == 0) begin
                    $error("unexpected result beat: median_value %0d frame_last %0b",
                           i_out_data.median_value, i_out_data.frame_last);
                    mismatches++;
                end else begin
                    due = medians_due.pop_front();
                    if (i_out_data.median_value !== due.median_value) begin
                        $error("median_value: expected %0d, got %0d",
                               due.median_value, i_out_data.median_value);
                        mismatches++;
                    end
                    if (i_out_data.frame_last !== due.frame_last) begin
                        $error("frame_last: expected %0b, got %0b",
                               due.frame_last, i_out_data.frame_last);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_median(i_in_data);
        end
        o_pending <= medians_due.size();
        o_errors  <= mismatches;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Bench top for the 3x3 median filter: clock, reset, frame configuration, pixel and
// flush beats with bursty timing, output stall pattern, watchdog and verdict.
// Depends on mf3_pkg, median_filter_3x3 and mf3_checker.
module testbench;

    localparam int   MAX_W         = mf3_pkg::DEF_MAX_WIDTH;
    localparam int   CLK_PERIOD    = 12;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   RANDOM_BEATS  = 960;
    localparam logic MODE_PIXEL    = 1'b0;
    localparam logic MODE_FLUSH    = 1'b1;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    mf3_pkg::t_in_beat               i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    mf3_pkg::t_out_beat              o_out_data;
    logic                            i_cfg_we    = 1'b0;
    logic [mf3_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [mf3_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    int         pending;
    int         errors;
    int         burst_left  = 0;
    int         frame_w     = 1;    // sizes as the block uses them
    int         frame_h     = 1;
    int         beats_sent  = 0;
    int         cycle_count = 0;
    logic [9:0] stall_phase = '0;

    median_filter_3x3 #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mf3_checker #(
        .MAX_WIDTH (MAX_W)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Output stall: free, light, heavy and periodic stretches in turn
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2'd2: i_out_stall <= ($urandom_range(0, 99) < 75);
            default: i_out_stall <= (stall_phase[2:0] < 3'd3);
        endcase
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // One input beat; bursts of random length separated by random gaps
    task automatic send_beat(input logic mode, input mf3_pkg::t_pix value);
        int   gap;
        logic taken;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= '{mode: mode, red_value: value};
        // stall as settled before the edge decides whether the edge takes the beat
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        beats_sent++;
    endtask

    // Hold off until every expected result is out and the pipeline is empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both size registers; only called while the block is idle
    task automatic set_frame(input logic [12:0] raw_w, input logic [12:0] raw_h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= mf3_pkg::CFG_FRAME_WIDTH;
        i_cfg_wdata <= raw_w;
        @(posedge i_clk);
        i_cfg_index <= mf3_pkg::CFG_FRAME_HEIGHT;
        i_cfg_wdata <= raw_h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        frame_w = (raw_w[10:0] == 0) ? 1 : (raw_w[10:0] > MAX_W) ? MAX_W : raw_w[10:0];
        frame_h = (raw_h == 0) ? 1 : (raw_h > mf3_pkg::MAX_HEIGHT) ? mf3_pkg::MAX_HEIGHT
                                                                  : raw_h;
    endtask

    // One whole frame: pixels with stray flushes, then width + 1 trailing beats
    task automatic run_frame(input int noise_pct);
        int            style;
        int            sent;
        mf3_pkg::t_pix value;
        style = $urandom_range(0, 3);
        sent  = 0;
        while (sent < frame_w * frame_h) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_beat(MODE_FLUSH, 8'($urandom));
            end else begin
                case (style)
                    0: value = 8'($urandom);
                    1: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    2: value = 8'($urandom_range(100, 115));
                    default: value = ($urandom_range(0, 4) == 0) ? 8'hFF
                                                                 : 8'($urandom_range(0, 40));
                endcase
                send_beat(MODE_PIXEL, value);
                sent++;
            end
        end
        // a pixel among the trailing beats only pushes the last row out
        for (int i = 0; i <= frame_w; i++)
            send_beat(($urandom_range(0, 99) < noise_pct) ? MODE_PIXEL : MODE_FLUSH,
                      8'($urandom));
        // surplus flush falls into the next frame and is dropped
        if ($urandom_range(0, 99) < noise_pct) send_beat(MODE_FLUSH, 8'($urandom));
    endtask

    initial begin
        int random_start;
        int raw_w;
        int raw_h;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 of alternating extremes, an early flush, a pixel among the
        // trailing beats and a surplus flush
        set_frame(13'd3, 13'd3);
        for (int i = 0; i < 9; i++) begin
            send_beat(MODE_PIXEL, i[0] ? 8'h00 : 8'hFF);
            if (i == 4) send_beat(MODE_FLUSH, 8'h5A);
        end
        send_beat(MODE_FLUSH, 8'h00);
        send_beat(MODE_PIXEL, 8'hFF);
        send_beat(MODE_FLUSH, 8'hFF);
        send_beat(MODE_FLUSH, 8'h00);
        send_beat(MODE_FLUSH, 8'hA5);
        drain_results();

        // zero sizes count as one: single-pixel frame
        set_frame(13'd0, 13'd0);
        send_beat(MODE_PIXEL, 8'hFF);
        send_beat(MODE_FLUSH, 8'h00);
        send_beat(MODE_PIXEL, 8'h81);
        drain_results();

        // one row of two
        set_frame(13'd2, 13'd1);
        send_beat(MODE_PIXEL, 8'h7F);
        send_beat(MODE_PIXEL, 8'h80);
        send_beat(MODE_FLUSH, 8'h00);
        send_beat(MODE_FLUSH, 8'hFF);
        send_beat(MODE_FLUSH, 8'h00);
        drain_results();

        // random frames, mostly small, a few wider and a few degenerate
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS) begin
            case ($urandom_range(0, 9))
                0: begin
                    raw_w = $urandom_range(9, 40);
                    raw_h = $urandom_range(2, 10);
                end
                1: begin
                    raw_w = $urandom_range(0, 2);
                    raw_h = $urandom_range(0, 2);
                end
                default: begin
                    raw_w = $urandom_range(1, 8);
                    raw_h = $urandom_range(1, 6);
                end
            endcase
            set_frame(13'(raw_w), 13'(raw_h));
            repeat ($urandom_range(1, 3))
                run_frame($urandom_range(0, 1) ? 0 : $urandom_range(2, 15));
            drain_results();
        end

        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ median_filter_3x3.f @@
+incdir+rtl/core
rtl/core/mf3_pkg.sv
rtl/core/mf3_line_buf.sv
rtl/core/mf3_ctrl.sv
rtl/core/mf3_median.sv
rtl/core/median_filter_3x3.sv
bench/mf3_checker.sv
bench/testbench.sv
